[sv/ris_pkg.sv]
// Shared types and constants for the ray/sphere intersection pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none
package ris_pkg;

  // Fraction bits of every coordinate.
  localparam int FRAC_BITS = 16;

  // Stream widths.
  localparam int IN_W  = 320;
  localparam int OUT_W = 128;

  // Square root: radicand, root and partial remainder widths.
  localparam int DW   = 134;
  localparam int RW   = DW / 2;
  localparam int REMW = RW + 3;

  // Distance reported when there is no usable root, saturated to 32 bits.
  localparam longint SENT_FULL = 64'sd20000 <<< FRAC_BITS;
  localparam longint SENT_SAT  = (SENT_FULL > 64'sd2147483647) ? 64'sd2147483647 : SENT_FULL;
  localparam logic signed [31:0] SENTINEL = SENT_SAT[31:0];

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_t;

  typedef struct packed {
    ray_t               ray;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic        [30:0] radius;
  } in_t;

  // Data that rides alongside the square root cells.
  typedef struct packed {
    ray_t               ray;
    logic signed [66:0] b;
    logic               dneg;
  } side_t;

  // Digit recurrence state of the square root.
  typedef struct packed {
    logic [REMW-1:0] rem;
    logic [RW-1:0]   root;
    logic [DW-1:0]   rad;
  } sqrt_t;

endpackage
`default_nettype wire

[sv/ris_sqrt_cell.sv]
// One cell of the square root chain: settles one root bit per cell.
// Depends on ris_pkg.
`default_nettype none
module ris_sqrt_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  ris_pkg::side_t     in_side,
  input  ris_pkg::sqrt_t     in_sq,
  output logic               out_valid,
  output ris_pkg::side_t     out_side,
  output ris_pkg::sqrt_t     out_sq
);
  import ris_pkg::*;

  logic [REMW-1:0] rem_sh;
  logic [REMW-1:0] trial;
  logic            ge;
  sqrt_t           sq_next;

  always_comb begin
    rem_sh = {in_sq.rem[REMW-3:0], in_sq.rad[DW-1 -: 2]};
    trial  = {1'b0, in_sq.root, 2'b01};
    ge     = (rem_sh >= trial);
    sq_next.rem  = ge ? (rem_sh - trial) : rem_sh;
    sq_next.root = {in_sq.root[RW-2:0], ge};
    sq_next.rad  = {in_sq.rad[DW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_sq   <= sq_next;
    end
  end

endmodule
`default_nettype wire

[sv/ris_front.sv]
// Front pipeline: A, B, C and the discriminant, seven register stages.
// Depends on ris_pkg.
`default_nettype none
module ris_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  ris_pkg::in_t        in_item,
  output logic                out_valid,
  output ris_pkg::side_t      out_side,
  output logic [ris_pkg::DW-1:0] out_rad
);
  import ris_pkg::*;

  logic [7:1] v;

  // stage 1
  ray_t               ray1;
  logic signed [32:0] dst1 [3];
  logic        [30:0] rad1;
  // stage 2
  ray_t               ray2;
  logic signed [63:0] pdd2 [3];
  logic signed [64:0] pdx2 [3];
  logic signed [65:0] pxx2 [3];
  logic        [61:0] rr2;
  // stage 3
  ray_t               ray3;
  logic        [63:0] a3;
  logic signed [66:0] b3;
  logic signed [66:0] c3;
  // stage 4
  ray_t               ray4;
  logic        [63:0] a4;
  logic signed [66:0] b4;
  logic        [65:0] bm4;
  logic        [65:0] cm4;
  logic               cn4;
  // stage 5
  ray_t               ray5;
  logic signed [66:0] b5;
  logic        [65:0] bb_hh5, bb_hl5, bb_ll5;
  logic        [64:0] ac005, ac015, ac105, ac115;
  logic               cn5;
  // stage 6
  ray_t               ray6;
  logic signed [66:0] b6;
  logic       [131:0] bsq6;
  logic       [129:0] ac6;
  logic               cn6;

  logic signed [31:0] org_in [3];
  logic signed [31:0] cen_in [3];
  logic signed [31:0] dir1 [3];
  logic signed [65:0] bsum;
  logic        [66:0] bneg;
  logic        [66:0] cneg;
  logic       [135:0] ac_x4;
  logic       [135:0] d;

  always_comb begin
    org_in[0] = in_item.ray.origin_x;
    org_in[1] = in_item.ray.origin_y;
    org_in[2] = in_item.ray.origin_z;
    cen_in[0] = in_item.center_x;
    cen_in[1] = in_item.center_y;
    cen_in[2] = in_item.center_z;
    dir1[0]   = ray1.dir_x;
    dir1[1]   = ray1.dir_y;
    dir1[2]   = ray1.dir_z;
    bsum      = pdx2[0] + pdx2[1] + pdx2[2];
    bneg      = -b3;
    cneg      = -c3;
    ac_x4     = {4'b0000, ac6, 2'b00};
    d         = cn6 ? ({4'b0000, bsq6} + ac_x4) : ({4'b0000, bsq6} - ac_x4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[6:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // difference of origin and center
      ray1 <= in_item.ray;
      rad1 <= in_item.radius;
      for (int i = 0; i < 3; i++) begin
        dst1[i] <= $signed({org_in[i][31], org_in[i]}) - $signed({cen_in[i][31], cen_in[i]});
      end
      // the ten products
      ray2 <= ray1;
      rr2  <= rad1 * rad1;
      for (int i = 0; i < 3; i++) begin
        pdd2[i] <= dir1[i] * dir1[i];
        pdx2[i] <= dir1[i] * dst1[i];
        pxx2[i] <= dst1[i] * dst1[i];
      end
      // A, B, C
      ray3 <= ray2;
      a3   <= pdd2[0] + pdd2[1] + pdd2[2];
      b3   <= {bsum, 1'b0};
      c3   <= pxx2[0] + pxx2[1] + pxx2[2] - $signed({1'b0, rr2});
      // magnitudes for the wide products
      ray4 <= ray3;
      a4   <= a3;
      b4   <= b3;
      bm4  <= b3[66] ? bneg[65:0] : b3[65:0];
      cm4  <= c3[66] ? cneg[65:0] : c3[65:0];
      cn4  <= c3[66];
      // partial products of B*B and A*|C|
      ray5   <= ray4;
      b5     <= b4;
      cn5    <= cn4;
      bb_hh5 <= bm4[65:33] * bm4[65:33];
      bb_hl5 <= bm4[65:33] * bm4[32:0];
      bb_ll5 <= bm4[32:0] * bm4[32:0];
      ac005  <= a4[31:0] * cm4[32:0];
      ac015  <= a4[31:0] * cm4[65:33];
      ac105  <= a4[63:32] * cm4[32:0];
      ac115  <= a4[63:32] * cm4[65:33];
      // sum the partial products
      ray6 <= ray5;
      b6   <= b5;
      cn6  <= cn5;
      bsq6 <= ({66'd0, bb_hh5} << 66) + ({66'd0, bb_hl5} << 34) + {66'd0, bb_ll5};
      ac6  <= ({65'd0, ac115} << 65) + ({65'd0, ac015} << 33)
            + ({65'd0, ac105} << 32) + {65'd0, ac005};
      // discriminant
      out_side.ray  <= ray6;
      out_side.b    <= b6;
      out_side.dneg <= d[135];
      out_rad       <= d[135] ? '0 : d[DW-1:0];
    end
  end

  assign out_valid = v[7];

endmodule
`default_nettype wire

[sv/ris_back.sv]
// Back pipeline: roots, hit test, distance and hit point, four stages.
// Depends on ris_pkg.
`default_nettype none
module ris_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  ris_pkg::side_t          in_side,
  input  wire logic [ris_pkg::RW-1:0] in_root,
  output logic                    out_valid,
  output logic                    out_hit,
  output logic signed [31:0]      out_distance,
  output logic signed [31:0]      out_point_x,
  output logic signed [31:0]      out_point_y,
  output logic signed [31:0]      out_point_z
);
  import ris_pkg::*;

  localparam logic signed [68:0] MAX32 = 69'sd2147483647;
  localparam logic signed [68:0] MIN32 = -69'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [68:0] x);
    logic signed [31:0] r;
    if (x > MAX32) begin
      r = MAX32[31:0];
    end else if (x < MIN32) begin
      r = MIN32[31:0];
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  logic [4:1] v;

  logic signed [68:0] bx, sx;
  // stage 1
  ray_t               ray1;
  logic signed [68:0] n01, n11;
  logic               dneg1;
  // stage 2
  ray_t               ray2;
  logic signed [31:0] dist2;
  logic               hit2;
  // stage 3
  logic signed [31:0] org3 [3];
  logic signed [63:0] prod3 [3];
  logic signed [31:0] dist3;
  logic               hit3;

  logic               pos0, neg0;
  logic signed [68:0] t0s, t1s;
  logic signed [31:0] dir2 [3];
  logic signed [31:0] org2 [3];
  logic signed [68:0] psum [3];

  always_comb begin
    bx   = {{2{in_side.b[66]}}, in_side.b};
    sx   = {2'b00, in_root};
    pos0 = !n01[68] && (n01 != '0);
    neg0 = n01[68];
    t0s  = n01 >>> (FRAC_BITS + 1);
    t1s  = n11 >>> (FRAC_BITS + 1);
    dir2[0] = ray2.dir_x;
    dir2[1] = ray2.dir_y;
    dir2[2] = ray2.dir_z;
    org2[0] = ray2.origin_x;
    org2[1] = ray2.origin_y;
    org2[2] = ray2.origin_z;
    for (int i = 0; i < 3; i++) begin
      psum[i] = org3[i] + (prod3[i] >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // both roots, exact
      ray1  <= in_side.ray;
      dneg1 <= in_side.dneg;
      n01   <= -bx - sx;
      n11   <= -bx + sx;
      // pick the root and scale it
      ray2 <= ray1;
      hit2 <= !dneg1 && pos0;
      if (dneg1) begin
        dist2 <= SENTINEL;
      end else if (pos0) begin
        dist2 <= sat32(t0s);
      end else if (neg0) begin
        dist2 <= sat32(t1s);
      end else begin
        dist2 <= SENTINEL;
      end
      // distance times direction
      dist3 <= dist2;
      hit3  <= hit2;
      for (int i = 0; i < 3; i++) begin
        org3[i]  <= org2[i];
        prod3[i] <= dist2 * dir2[i];
      end
      // hit point
      out_hit      <= hit3;
      out_distance <= dist3;
      out_point_x  <= sat32(psum[0]);
      out_point_y  <= sat32(psum[1]);
      out_point_z  <= sat32(psum[2]);
    end
  end

  assign out_valid = v[4];

endmodule
`default_nettype wire

[sv/ray_sphere_intersect.sv]
// Ray against sphere intersection: one ray and one sphere in, hit flag,
// distance and hit point out. Top level; uses ris_pkg, ris_front,
// ris_sqrt_cell and ris_back.
//
// Usage:
//  - Input stream (s_axis_*): one ray and sphere per transfer, packed in
//    s_axis_tdata. Output stream (m_axis_*): distance and point in
//    m_axis_tdata, the hit flag in m_axis_tuser. One result per input.
//  - The pipeline has 78 register stages: 7 front stages (products, sums,
//    discriminant), 67 square root cells (one root bit per cell), 4 back
//    stages (roots, distance, point). With m_axis_tready high the block
//    takes one item per cycle.
//  - All stages advance together while the output register is empty or
//    being read. When the receiver stalls, the pipeline holds, and a
//    one-entry skid buffer still takes the next input transfer; input
//    ready drops only while that buffer is full.
//  - Reset (rst, synchronous) clears every valid bit and the skid buffer;
//    items in flight are dropped.
//  - No state is kept between items.
`default_nettype none
module ray_sphere_intersect (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
  // center_x, center_y, center_z, radius, one zero pad bit
  input  wire logic [ris_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // distance, point_x, point_y, point_z
  output logic [ris_pkg::OUT_W-1:0]    m_axis_tdata,
  // hit
  output logic                         m_axis_tuser
);
  import ris_pkg::*;

  logic en;
  logic take;
  logic skid_valid;
  in_t  skid_data;
  in_t  in_item;
  in_t  src_item;
  logic src_valid;

  logic           front_valid;
  side_t          front_side;
  logic [DW-1:0]  front_rad;

  logic  [RW:0]   cv;
  side_t          cside [RW+1];
  sqrt_t          csq   [RW+1];

  logic               hit;
  logic signed [31:0] distance, point_x, point_y, point_z;

  // Unpack the input transfer, first field in the lowest bits.
  always_comb begin
    in_item.ray.origin_x = s_axis_tdata[31:0];
    in_item.ray.origin_y = s_axis_tdata[63:32];
    in_item.ray.origin_z = s_axis_tdata[95:64];
    in_item.ray.dir_x    = s_axis_tdata[127:96];
    in_item.ray.dir_y    = s_axis_tdata[159:128];
    in_item.ray.dir_z    = s_axis_tdata[191:160];
    in_item.center_x     = s_axis_tdata[223:192];
    in_item.center_y     = s_axis_tdata[255:224];
    in_item.center_z     = s_axis_tdata[287:256];
    in_item.radius       = s_axis_tdata[318:288];
  end

  // Advance the whole pipeline when the output register is free.
  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = ~skid_valid;
  assign take          = s_axis_tvalid & s_axis_tready;
  assign src_valid     = skid_valid | take;
  assign src_item      = skid_valid ? skid_data : in_item;

  // Skid buffer: hold a transfer that arrives while the pipeline stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take & ~en) begin
      skid_data <= in_item;
    end
  end

  ris_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (src_valid),
    .in_item   (src_item),
    .out_valid (front_valid),
    .out_side  (front_side),
    .out_rad   (front_rad)
  );

  // Square root chain: cell k settles root bit RW-1-k.
  assign cv[0]        = front_valid;
  assign cside[0]     = front_side;
  assign csq[0].rem   = '0;
  assign csq[0].root  = '0;
  assign csq[0].rad   = front_rad;

  for (genvar k = 0; k < RW; k++) begin : g_cell
    ris_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cv[k]),
      .in_side   (cside[k]),
      .in_sq     (csq[k]),
      .out_valid (cv[k+1]),
      .out_side  (cside[k+1]),
      .out_sq    (csq[k+1])
    );
  end

  ris_back u_back (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (cv[RW]),
    .in_side      (cside[RW]),
    .in_root      (csq[RW].root),
    .out_valid    (m_axis_tvalid),
    .out_hit      (hit),
    .out_distance (distance),
    .out_point_x  (point_x),
    .out_point_y  (point_y),
    .out_point_z  (point_z)
  );

  assign m_axis_tdata = {point_z, point_y, point_x, distance};
  assign m_axis_tuser = hit;

  // The skid buffer fills only on a cycle when the pipeline is held.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> !$past(en))
    else $error("skid buffer filled while pipeline advanced");

  // A hit has a non-negative distance.
  a_hit_dist: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[31])
    else $error("hit reported with negative distance");

  // Nothing leaves the block in the cycle after reset.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !skid_valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

[bench/ray_sphere_intersect_check.sv]
`timescale 1ns / 1ps
// Checker for ray_sphere_intersect: watches both stream channels, predicts
// the hit, distance and point of each accepted ray and compares them.
// Depends on ris_pkg for the stream widths, the fraction bits and the sentinel.
module ray_sphere_intersect_check (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  input  wire logic                      s_axis_tready,
  input  wire logic [ris_pkg::IN_W-1:0]  s_axis_tdata,
  input  wire logic                      m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  input  wire logic [ris_pkg::OUT_W-1:0] m_axis_tdata,
  input  wire logic                      m_axis_tuser,
  output int                             errors,
  output int                             pending
);
  localparam int FB = ris_pkg::FRAC_BITS;

  typedef logic signed [159:0] wide_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] point_z;
    logic signed [31:0] point_y;
    logic signed [31:0] point_x;
    logic signed [31:0] distance;
  } hit_info_t;

  hit_info_t expected_hits[$];

  function automatic logic signed [31:0] clamp32(wide_t v);
    if (v < -wide_t'(64'sh80000000)) return 32'sh80000000;
    if (v > wide_t'(64'sh7fffffff)) return 32'sh7fffffff;
    return v[31:0];
  endfunction

  // Floor square root, one root bit at a time from the top.
  function automatic wide_t floor_root(wide_t disc);
    wide_t root, cand;
    root = '0;
    for (int b = 70; b >= 0; b--) begin
      cand = root;
      cand[b] = 1'b1;
      if (cand * cand <= disc) root = cand;
    end
    return root;
  endfunction

  function automatic hit_info_t intersect_ray(logic [ris_pkg::IN_W-1:0] d);
    hit_info_t r;
    longint org[3], dir[3], diff[3], rad, dist_q, p;
    wide_t x, y, a, bd, b, c, disc, root, near_num;
    a = '0;
    bd = '0;
    c = '0;
    for (int i = 0; i < 3; i++) begin
      org[i] = longint'($signed(d[32*i +: 32]));
      dir[i] = longint'($signed(d[32*(3+i) +: 32]));
      diff[i] = org[i] - longint'($signed(d[32*(6+i) +: 32]));
      x = dir[i];
      y = diff[i];
      a += x * x;
      bd += x * y;
      c += y * y;
    end
    rad = longint'(d[288 +: 31]);
    b = bd + bd;
    x = rad;
    c -= x * x;
    disc = b * b - 4 * a * c;
    r.hit = 1'b0;
    r.distance = ris_pkg::SENTINEL;
    if (disc >= 0) begin
      root = floor_root(disc);
      near_num = -b - root;
      if (near_num > 0) begin
        r.hit = 1'b1;
        r.distance = clamp32(near_num >>> (FB + 1));
      end else if (near_num < 0) begin
        r.distance = clamp32((-b + root) >>> (FB + 1));
      end
    end
    dist_q = longint'(r.distance);
    for (int i = 0; i < 3; i++) begin
      p = org[i] + ((dist_q * dir[i]) >>> FB);
      x = p;
      case (i)
        0: r.point_x = clamp32(x);
        1: r.point_y = clamp32(x);
        default: r.point_z = clamp32(x);
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, longint want, longint got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
    errors++;
  endtask

  initial errors = 0;
  assign pending = expected_hits.size();

  always @(posedge clk) begin
    hit_info_t want, got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) expected_hits.push_back(intersect_ray(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata};
        if (expected_hits.size() == 0) begin
          $display("%0t: result transfer with no ray outstanding", $realtime);
          errors++;
        end else begin
          want = expected_hits.pop_front();
          if (want.hit != got.hit) report_mismatch("hit", want.hit, got.hit);
          if (want.distance != got.distance)
            report_mismatch("distance", want.distance, got.distance);
          if (want.point_x != got.point_x) report_mismatch("point_x", want.point_x, got.point_x);
          if (want.point_y != got.point_y) report_mismatch("point_y", want.point_y, got.point_y);
          if (want.point_z != got.point_z) report_mismatch("point_z", want.point_z, got.point_z);
        end
      end
    end
  end
endmodule

[bench/ray_sphere_intersect_test.sv]
`timescale 1ns / 1ps
// Top of the ray_sphere_intersect bench: drives rays and spheres with bursty
// timing and a stalling receiver; ray_sphere_intersect_check does the checking.
// Depends on ris_pkg, ray_sphere_intersect and ray_sphere_intersect_check.
module ray_sphere_intersect_test;
  localparam int ONE = 1 << ris_pkg::FRAC_BITS;
  localparam int RANDOM_RAYS = 1240;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ris_pkg::IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [ris_pkg::OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  int errors, pending;

  ray_sphere_intersect dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  ray_sphere_intersect_check checker_i (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors, .pending
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Pack fields from the lowest bit up; the top pad bit stays zero.
  function automatic logic [ris_pkg::IN_W-1:0] pack_ray(
      int ox, int oy, int oz, int dx, int dy, int dz,
      int cx, int cy, int cz, logic [30:0] rad);
    return {1'b0, rad, cz, cy, cx, dz, dy, dx, oz, oy, ox};
  endfunction

  // Offer one transfer from a falling edge, hold it until accepted, and
  // return on the falling edge after acceptance with tvalid still high.
  task automatic send_ray(logic [ris_pkg::IN_W-1:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  function automatic int coord(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // Mostly well-formed scenes near the origin with unit directions; the rest
  // is raw noise over the full field range.
  function automatic logic [ris_pkg::IN_W-1:0] random_scene();
    int d[3];
    int axis, sgn;
    logic [30:0] rad;
    if ($urandom_range(9) < 2)
      return pack_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, 31'($urandom));
    d = '{0, 0, 0};
    axis = $urandom_range(2);
    sgn = $urandom_range(1) ? ONE : -ONE;
    if ($urandom_range(3) == 0) begin
      // diagonal of roughly unit length
      d[axis] = sgn / 65536 * 46341;
      d[(axis + 1) % 3] = $urandom_range(1) ? 46341 : -46341;
    end else begin
      d[axis] = sgn;
    end
    rad = ($urandom_range(15) == 0) ? 31'($urandom) : 31'($urandom_range(50 * ONE));
    return pack_ray(coord(100 * ONE), coord(100 * ONE), coord(100 * ONE), d[0], d[1], d[2],
                    coord(60 * ONE), coord(60 * ONE), coord(60 * ONE), rad);
  endfunction

  // Receiver: one long hold-off so the pipeline and skid buffer fill, then
  // alternate random stall patterns with stretches of full throughput.
  initial begin
    int mode;
    @(negedge rst);
    repeat (50) @(negedge clk) m_axis_tready <= $urandom_range(1);
    m_axis_tready <= 1'b0;
    repeat (300) @(negedge clk);
    forever begin
      mode = $urandom_range(3);
      repeat ($urandom_range(10, 80)) begin
        @(negedge clk);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(3) != 0);
          2: m_axis_tready <= ($urandom_range(3) == 0);
          default: m_axis_tready <= 1'b0;
        endcase
      end
    end
  end

  // Stimulus.
  initial begin
    int burst;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extremes of every field
    send_ray(pack_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                      32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                      32'sh80000000, 31'h7fffffff));
    send_ray(pack_ray(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                      32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                      32'sh7fffffff, '0));
    send_ray(pack_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
    send_ray('1 >> 1);
    // plain hit in front, sphere behind, and origin inside the sphere
    send_ray(pack_ray(0, 0, 0, ONE, 0, 0, 10 * ONE, 0, 0, 31'(2 * ONE)));
    send_ray(pack_ray(0, 0, 0, -ONE, 0, 0, 10 * ONE, 0, 0, 31'(2 * ONE)));
    send_ray(pack_ray(ONE / 2, 0, 0, 0, ONE, 0, 0, 0, 0, 31'(3 * ONE)));
    // negative discriminant: ray passes beside the sphere
    send_ray(pack_ray(0, 5 * ONE, 0, ONE, 0, 0, 10 * ONE, 0, 0, 31'(ONE)));
    // a root exactly zero: origin on the surface, ray going in and ray leaving it
    send_ray(pack_ray(ONE, 0, 0, -ONE, 0, 0, 0, 0, 0, 31'(ONE)));
    send_ray(pack_ray(ONE, 0, 0, ONE, 0, 0, 0, 0, 0, 31'(ONE)));
    // tangent ray
    send_ray(pack_ray(0, ONE, 0, 0, 0, ONE, 0, 0, 8 * ONE, 31'(ONE)));
    // non-unit direction and huge radius with saturated distance and point
    send_ray(pack_ray(3 * ONE, -ONE, 7, 5 * ONE, -2 * ONE, ONE, 0, 0, 0, 31'(4 * ONE)));
    send_ray(pack_ray(0, 0, 0, ONE, 0, 0, 0, 0, 0, 31'h7fffffff));
    send_ray(pack_ray(32'sh7fff0000, 0, 0, ONE, ONE, ONE, 0, 0, 0, 31'h40000000));

    for (int n = 0; n < RANDOM_RAYS; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < RANDOM_RAYS; k++, n++) send_ray(random_scene());
      if ($urandom_range(2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end
endmodule

[filelist.f]
sv/ris_pkg.sv
sv/ris_sqrt_cell.sv
sv/ris_front.sv
sv/ris_back.sv
sv/ray_sphere_intersect.sv
bench/ray_sphere_intersect_check.sv
bench/ray_sphere_intersect_test.sv
